### rtl/fpba_pkg.sv
// Shared types and constants for the fit-policy block allocator.
package fpba_pkg;

	localparam int IDX_W = 4;
	localparam int CFG_W = 5;
	localparam int POL_W = 2;

	localparam logic [POL_W-1:0] POLICY_FIRST = 2'd0;
	localparam logic [POL_W-1:0] POLICY_BEST  = 2'd1;
	localparam logic [POL_W-1:0] POLICY_WORST = 2'd2;

	localparam logic [CFG_W-1:0] BLOCK_COUNT_RST = 5'd16;

	typedef enum logic [0:0] {
		CFG_FIT_POLICY  = 1'b0,
		CFG_BLOCK_COUNT = 1'b1
	} cfg_idx_t;

	typedef enum logic [0:0] {
		OP_LOAD    = 1'b0,
		OP_REQUEST = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_WB
	} state_t;

	typedef struct packed {
		logic load;
		logic start;
		logic scan_rd;
		logic wb;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
		logic n_zero;
		logic last_rd;
	} status_t;

endpackage

### rtl/fpba_in_if.sv
// Input channel: load or allocation request.
interface fpba_in_if #(
	parameter int SIZE_BITS = 16
);
	logic                      valid;
	logic                      ready;
	logic                      operation;
	logic [fpba_pkg::IDX_W-1:0] block_index;
	logic [SIZE_BITS-1:0]      size;

	modport source (output valid, output operation, output block_index, output size,
		input ready);
	modport sink (input valid, input operation, input block_index, input size,
		output ready);
endinterface

### rtl/fpba_out_if.sv
// Output channel: allocation result.
interface fpba_out_if #(
	parameter int SIZE_BITS = 16
);
	logic                      valid;
	logic                      ready;
	logic                      granted;
	logic [fpba_pkg::IDX_W-1:0] chosen_block;
	logic [SIZE_BITS-1:0]      remaining_size;

	modport source (output valid, output granted, output chosen_block,
		output remaining_size, input ready);
	modport sink (input valid, input granted, input chosen_block,
		input remaining_size, output ready);
endinterface

### rtl/fpba_ctrl.sv
// Allocator sequencer: accepts items, steps the scan, triggers write-back.
module fpba_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_operation,
	output logic              in_ready,
	input  fpba_pkg::status_t st,
	output fpba_pkg::cmd_t    cmd
);
	import fpba_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = !st.out_busy;
				if (in_valid && !st.out_busy) begin
					if (op_t'(in_operation) == OP_REQUEST) begin
						cmd.start = 1'b1;
						state_d   = st.n_zero ? ST_WB : ST_SCAN;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (st.last_rd) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_WB;
			end
			ST_WB: begin
				cmd.wb  = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/fpba_dp.sv
// Allocator datapath: config, free-size memory, scan compare, result register.
module fpba_dp #(
	parameter int MAX_BLOCKS = 16,
	parameter int SIZE_BITS  = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  fpba_pkg::cfg_idx_t         cfg_index,
	input  logic [fpba_pkg::CFG_W-1:0] cfg_data,
	input  logic [fpba_pkg::IDX_W-1:0] in_block_index,
	input  logic [SIZE_BITS-1:0]       in_size,
	input  fpba_pkg::cmd_t             cmd,
	output fpba_pkg::status_t          st,
	input  logic                       out_ready,
	output logic                       out_valid,
	output logic                       out_granted,
	output logic [fpba_pkg::IDX_W-1:0] out_chosen_block,
	output logic [SIZE_BITS-1:0]       out_remaining_size
);
	import fpba_pkg::*;

	localparam int AW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);

	logic [POL_W-1:0]     fit_policy_q;
	logic [CFG_W-1:0]     block_count_q;
	logic [CW-1:0]        n_use;

	logic [SIZE_BITS-1:0] mem_q [MAX_BLOCKS];
	logic                 vld_q [MAX_BLOCKS];
	logic                 mem_we;
	logic [AW-1:0]        mem_wa;
	logic [SIZE_BITS-1:0] mem_wd;
	logic                 load_ok;

	logic [AW-1:0]        addr_q;
	logic [SIZE_BITS-1:0] want_q;
	logic                 s1_valid_q;
	logic [SIZE_BITS-1:0] rd_data_s1;
	logic                 rd_vld_s1;
	logic [AW-1:0]        rd_idx_s1;

	logic [SIZE_BITS-1:0] have;
	logic                 take;
	logic                 found_q;
	logic [AW-1:0]        best_idx_q;
	logic [SIZE_BITS-1:0] best_size_q;
	logic [SIZE_BITS-1:0] diff;

	logic                 out_valid_q;
	logic                 granted_q;
	logic [IDX_W-1:0]     chosen_q;
	logic [SIZE_BITS-1:0] remaining_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_policy_q  <= POLICY_FIRST;
			block_count_q <= BLOCK_COUNT_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_FIT_POLICY) begin
				fit_policy_q <= cfg_data[POL_W-1:0];
			end
			if (cfg_index == CFG_BLOCK_COUNT) begin
				block_count_q <= cfg_data;
			end
		end
	end

	assign n_use = (int'(block_count_q) > MAX_BLOCKS) ? CW'(MAX_BLOCKS) : CW'(block_count_q);

	// free-size memory, entries read as zero until written
	assign load_ok = cmd.load && (int'(in_block_index) < MAX_BLOCKS);
	assign diff    = best_size_q - want_q;
	assign mem_we  = load_ok || (cmd.wb && found_q);
	assign mem_wa  = cmd.wb ? best_idx_q : AW'(in_block_index);
	assign mem_wd  = cmd.wb ? diff : in_size;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		if (cmd.scan_rd) begin
			rd_data_s1 <= mem_q[addr_q];
			rd_idx_s1  <= addr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_BLOCKS; i++) begin
				vld_q[i] <= 1'b0;
			end
			rd_vld_s1 <= 1'b0;
		end else begin
			if (mem_we) begin
				vld_q[mem_wa] <= 1'b1;
			end
			if (cmd.scan_rd) begin
				rd_vld_s1 <= vld_q[addr_q];
			end
		end
	end

	// scan address and compare stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q     <= '0;
			s1_valid_q <= 1'b0;
			found_q    <= 1'b0;
		end else begin
			s1_valid_q <= cmd.scan_rd;
			if (cmd.start) begin
				addr_q  <= '0;
				found_q <= 1'b0;
			end else begin
				if (cmd.scan_rd) begin
					addr_q <= addr_q + AW'(1);
				end
				if (take) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			want_q <= in_size;
		end
		if (take) begin
			best_idx_q  <= rd_idx_s1;
			best_size_q <= have;
		end
	end

	assign have = rd_vld_s1 ? rd_data_s1 : '0;

	always_comb begin
		take = 1'b0;
		if (s1_valid_q && (have >= want_q)) begin
			priority if (!found_q) begin
				take = 1'b1;
			end else if (fit_policy_q == POLICY_BEST) begin
				take = have < best_size_q;
			end else if (fit_policy_q == POLICY_WORST) begin
				take = have > best_size_q;
			end else begin
				take = 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.wb) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wb) begin
			granted_q   <= found_q;
			chosen_q    <= found_q ? IDX_W'(best_idx_q) : '0;
			remaining_q <= found_q ? diff : '0;
		end
	end

	assign out_valid          = out_valid_q;
	assign out_granted        = granted_q;
	assign out_chosen_block   = chosen_q;
	assign out_remaining_size = remaining_q;

	assign st.out_busy = out_valid_q && !out_ready;
	assign st.n_zero   = (n_use == '0);
	assign st.last_rd  = (CW'(addr_q) == CW'(n_use - CW'(1)));

endmodule

### rtl/fit_policy_block_allocator_core.sv
// Top level of the fit-policy block allocator.
// Load item: written in the cycle of its transfer, no result.
// Request: one free-size memory read per cycle over blocks 0..n-1, n = blocks in use,
//   then one write-back that presents the result.
// A new request is taken only when idle, once the previous result has left or leaves
//   that cycle; loads likewise, one per cycle. Reset (arst_n low): policy first
//   fit, block count 16, all free sizes read as zero.
module fit_policy_block_allocator_core #(
	parameter int MAX_BLOCKS = 16,
	parameter int SIZE_BITS  = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  fpba_pkg::cfg_idx_t         cfg_index,
	input  logic [fpba_pkg::CFG_W-1:0] cfg_data,
	fpba_in_if.sink                    in_ch,
	fpba_out_if.source                 out_ch
);
	import fpba_pkg::*;

	cmd_t    cmd;
	status_t st;

	fpba_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_ch.valid),
		.in_operation (in_ch.operation),
		.in_ready     (in_ch.ready),
		.st           (st),
		.cmd          (cmd)
	);

	fpba_dp #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.SIZE_BITS  (SIZE_BITS)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_block_index     (in_ch.block_index),
		.in_size            (in_ch.size),
		.cmd                (cmd),
		.st                 (st),
		.out_ready          (out_ch.ready),
		.out_valid          (out_ch.valid),
		.out_granted        (out_ch.granted),
		.out_chosen_block   (out_ch.chosen_block),
		.out_remaining_size (out_ch.remaining_size)
	);

	a_wb_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wb |-> !st.out_busy)
		else $error("write-back while result slot is stalled");

	a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_rd |-> !in_ch.ready && !cmd.start && !cmd.load)
		else $error("input accepted during scan");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.granted) |->
		(out_ch.chosen_block == '0) && (out_ch.remaining_size == '0))
		else $error("refused result carries nonzero fields");

	a_result_after_wb: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wb |=> out_ch.valid)
		else $error("write-back did not present a result");

endmodule

### bench/tb_fit_policy_block_allocator_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for the fit-policy block allocator core.
module tb_fit_policy_block_allocator_core;
	import fpba_pkg::*;

	localparam int MAX_BLOCKS    = 16;
	localparam int SIZE_BITS     = 16;
	localparam int SETTLE_CYCLES = 24;
	localparam int RAND_PHASES   = 16;
	localparam int PHASE_ITEMS   = 58;

	typedef struct packed {
		logic                 granted;
		logic [IDX_W-1:0]     chosen_block;
		logic [SIZE_BITS-1:0] remaining_size;
	} grant_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	cfg_idx_t             cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	fpba_in_if  #(.SIZE_BITS(SIZE_BITS)) in_ch ();
	fpba_out_if #(.SIZE_BITS(SIZE_BITS)) out_ch ();

	fit_policy_block_allocator_core #(
		.MAX_BLOCKS(MAX_BLOCKS),
		.SIZE_BITS (SIZE_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	// shadow of the allocator state
	logic [SIZE_BITS-1:0] free_tbl [MAX_BLOCKS];
	logic [POL_W-1:0]     policy_cfg;
	logic [CFG_W-1:0]     count_cfg;

	grant_t pending_grants [$];
	int     err_count;
	int     gap_pct;
	int     stall_pct;
	int     rx_hold;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic int blocks_in_use();
		return (count_cfg > MAX_BLOCKS) ? MAX_BLOCKS : int'(count_cfg);
	endfunction

	function automatic grant_t predict_grant(logic [SIZE_BITS-1:0] want);
		int     n;
		int     pick;
		bit     found;
		grant_t g;
		n = blocks_in_use();
		pick = 0;
		found = 1'b0;
		g = '0;
		for (int k = 0; k < n; k++) begin
			if (free_tbl[k] >= want) begin
				if (!found) begin
					found = 1'b1;
					pick = k;
					if (policy_cfg != POLICY_BEST && policy_cfg != POLICY_WORST)
						break;
				end else if (policy_cfg == POLICY_BEST && free_tbl[k] < free_tbl[pick]) begin
					pick = k;
				end else if (policy_cfg == POLICY_WORST && free_tbl[k] > free_tbl[pick]) begin
					pick = k;
				end
			end
		end
		if (found) begin
			free_tbl[pick] = free_tbl[pick] - want;
			g.granted = 1'b1;
			g.chosen_block = pick[IDX_W-1:0];
			g.remaining_size = free_tbl[pick];
		end
		return g;
	endfunction

	// valid stays high after a transfer; the next call decides what follows
	task automatic send_item(op_t op, logic [IDX_W-1:0] idx, logic [SIZE_BITS-1:0] sz);
		@(negedge clk);
		while ($urandom_range(99) < gap_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.operation   <= op;
		in_ch.block_index <= idx;
		in_ch.size        <= sz;
		do @(posedge clk); while (!in_ch.ready);
		if (op == OP_REQUEST)
			pending_grants.push_back(predict_grant(sz));
		else if (idx < MAX_BLOCKS)
			free_tbl[idx] = sz;
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (pending_grants.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t ri, logic [CFG_W-1:0] value);
		drain_results();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= ri;
		cfg_data  <= value;
		@(posedge clk);
		if (ri == CFG_FIT_POLICY)
			policy_cfg = value[POL_W-1:0];
		else
			count_cfg = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [SIZE_BITS-1:0] pick_load_size();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2, 3: return SIZE_BITS'($urandom_range(255));
			default: return SIZE_BITS'($urandom);
		endcase
	endfunction

	function automatic logic [SIZE_BITS-1:0] pick_request_size();
		int n;
		int k;
		n = blocks_in_use();
		k = (n == 0) ? 0 : $urandom_range(n - 1);
		case ($urandom_range(9))
			0: return '0;
			1: return SIZE_BITS'($urandom);
			2: return '1;
			3, 4: return free_tbl[k];
			5: return free_tbl[k] + 1'b1;
			6: return SIZE_BITS'($urandom_range(255));
			default: return SIZE_BITS'($urandom_range(free_tbl[k]));
		endcase
	endfunction

	task automatic test_after_reset();
		// table is zero: a zero-size request fits block 0, anything else is refused
		send_item(OP_REQUEST, '0, '0);
		send_item(OP_REQUEST, '0, 16'd1);
		send_item(OP_REQUEST, '1, '1);
	endtask

	task automatic test_fit_policies();
		write_reg(CFG_FIT_POLICY, CFG_W'(POLICY_FIRST));
		send_item(OP_LOAD, 4'd0, 16'd100);
		send_item(OP_LOAD, 4'd1, 16'd50);
		send_item(OP_LOAD, 4'd2, 16'hFFFF);
		send_item(OP_LOAD, 4'd3, 16'd50);
		send_item(OP_LOAD, 4'd4, 16'd200);
		send_item(OP_REQUEST, '0, 16'd40);
		write_reg(CFG_FIT_POLICY, CFG_W'(POLICY_BEST));
		send_item(OP_REQUEST, '0, 16'd45);
		send_item(OP_REQUEST, '0, 16'd50);
		write_reg(CFG_FIT_POLICY, CFG_W'(POLICY_WORST));
		send_item(OP_REQUEST, '0, 16'hFFFF);
		send_item(OP_REQUEST, '0, 16'd10);
		// unused policy code with stray upper bits acts as first fit
		write_reg(CFG_FIT_POLICY, 5'b101_11);
		send_item(OP_REQUEST, '0, 16'd1);
	endtask

	task automatic test_block_count_edges();
		write_reg(CFG_BLOCK_COUNT, 5'd0);
		send_item(OP_REQUEST, '0, '0);
		write_reg(CFG_BLOCK_COUNT, 5'd31);
		send_item(OP_REQUEST, '0, '0);
		write_reg(CFG_BLOCK_COUNT, 5'd1);
		send_item(OP_LOAD, 4'd15, 16'hFFFF);
		send_item(OP_REQUEST, '0, 16'h8000);
		write_reg(CFG_BLOCK_COUNT, 5'd16);
		send_item(OP_REQUEST, '0, 16'h8000);
	endtask

	task automatic test_back_pressure();
		write_reg(CFG_FIT_POLICY, CFG_W'(POLICY_BEST));
		write_reg(CFG_BLOCK_COUNT, 5'd16);
		gap_pct = 0;
		for (int k = 0; k < MAX_BLOCKS; k++)
			send_item(OP_LOAD, IDX_W'(k), pick_load_size());
		rx_hold = 300;
		for (int k = 0; k < 12; k++)
			send_item(OP_REQUEST, '0, pick_request_size());
		gap_pct = 8;
		drain_results();
	endtask

	task automatic test_random_traffic();
		logic [CFG_W-1:0] counts [8];
		logic [POL_W-1:0] pol;
		logic [CFG_W-1:0] cnt;
		int               n;
		counts = '{5'd1, 5'd16, 5'd2, 5'd31, 5'd0, 5'd3, 5'd17, 5'd8};
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			pol = (ph < 4) ? POL_W'(ph) : POL_W'($urandom_range(3));
			cnt = (ph < 8) ? counts[ph] : CFG_W'($urandom_range(1, 16));
			write_reg(CFG_FIT_POLICY, CFG_W'({CFG_W'($urandom_range(7)), pol}));
			write_reg(CFG_BLOCK_COUNT, cnt);
			if (ph == 4 || ph == 5) begin
				gap_pct = 0;
				stall_pct = 0;
			end else begin
				gap_pct = 8;
				stall_pct = 8;
			end
			n = blocks_in_use();
			for (int k = 0; k < n; k++)
				send_item(OP_LOAD, IDX_W'(k), pick_load_size());
			for (int i = n; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(99) < 30)
					send_item(OP_LOAD, IDX_W'($urandom_range(15)), pick_load_size());
				else
					send_item(OP_REQUEST, IDX_W'($urandom_range(15)), pick_request_size());
			end
		end
		drain_results();
	endtask

	// receiver: random stalls, plus a counted hold-off on request
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				out_ch.ready <= 1'b0;
				rx_hold--;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		grant_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_grants.size() == 0) begin
				$error("unexpected result: granted=%0d chosen_block=%0d remaining_size=%0d",
					out_ch.granted, out_ch.chosen_block, out_ch.remaining_size);
				err_count++;
			end else begin
				want = pending_grants.pop_front();
				if (out_ch.granted !== want.granted) begin
					$error("granted: expected %0d, got %0d", want.granted, out_ch.granted);
					err_count++;
				end
				if (out_ch.chosen_block !== want.chosen_block) begin
					$error("chosen_block: expected %0d, got %0d",
						want.chosen_block, out_ch.chosen_block);
					err_count++;
				end
				if (out_ch.remaining_size !== want.remaining_size) begin
					$error("remaining_size: expected %0d, got %0d",
						want.remaining_size, out_ch.remaining_size);
					err_count++;
				end
			end
		end
	end

	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = CFG_FIT_POLICY;
		cfg_data          = '0;
		in_ch.valid       = 1'b0;
		in_ch.operation   = OP_LOAD;
		in_ch.block_index = '0;
		in_ch.size        = '0;
		err_count         = 0;
		gap_pct           = 8;
		stall_pct         = 8;
		rx_hold           = 0;
		policy_cfg        = POLICY_FIRST;
		count_cfg         = BLOCK_COUNT_RST;
		for (int k = 0; k < MAX_BLOCKS; k++)
			free_tbl[k] = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_after_reset();
		test_fit_policies();
		test_block_count_edges();
		test_back_pressure();
		test_random_traffic();

		if (err_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
